>>> rtl/smpq_pkg.sv
// Shared types and constants for the stable minimum priority queue.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package smpq_pkg;

  localparam int Capacity   = 16;
  localparam int CntW       = $clog2(Capacity + 1);
  localparam int ValueW     = 32;
  localparam int PrioW      = 8;
  localparam int StatusW    = 2;
  localparam int EntryCntW  = 5;

  typedef enum logic {
    OpEnqueue = 1'b0,
    OpDequeue = 1'b1
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk        = 2'd0,
    StatusUnderflow = 2'd1,
    StatusOverflow  = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

>>> rtl/smpq_cell.sv
// One slot of the sorted chain: holds a value/priority pair and trades it
// with its neighbors. Depends on smpq_pkg.
module smpq_cell (
  input  logic                                clk_i,
  input  smpq_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                occupied_i,
  input  logic signed [smpq_pkg::ValueW-1:0]  new_value_i,
  input  logic        [smpq_pkg::PrioW-1:0]   new_prio_i,
  input  logic                                left_ins_i,
  input  logic signed [smpq_pkg::ValueW-1:0]  left_value_i,
  input  logic        [smpq_pkg::PrioW-1:0]   left_prio_i,
  input  logic signed [smpq_pkg::ValueW-1:0]  right_value_i,
  input  logic        [smpq_pkg::PrioW-1:0]   right_prio_i,
  output logic                                ins_o,
  output logic signed [smpq_pkg::ValueW-1:0]  value_o,
  output logic        [smpq_pkg::PrioW-1:0]   prio_o
);

  logic signed [smpq_pkg::ValueW-1:0] value_q, value_d;
  logic        [smpq_pkg::PrioW-1:0]  prio_q, prio_d;

  // Slot lies at or behind the insert point: free, or strictly less urgent.
  assign ins_o = ~occupied_i | (prio_q > new_prio_i);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctrl_i.pop) begin
      // advance toward the front
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end else if (ctrl_i.push && ins_o) begin
      if (left_ins_i) begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

>>> rtl/stable_min_priority_queue_core.sv
// Top level of the stable minimum priority queue: a chain of smpq_cell slots
// plus the occupancy counter and result register. Depends on smpq_pkg.
//
// Usage: the queue takes one request per clock. A request is accepted when
// start is high (busy is always low, so every start is taken). The result
// appears on the following cycle for exactly one cycle, marked by
// result_valid_o, and cannot be held off: capture it then. Throughput is one
// request per cycle, set by the compare-and-shift chain, where every slot
// decides locally whether to hold, take the new entry, take its front
// neighbor (insert) or take its back neighbor (dequeue). Slot 0 is the
// front; lower priority numbers leave first and equal priorities leave in
// arrival order. Head fields read zero when the queue is empty. Enqueue on
// a full queue reports overflow and dequeue on an empty queue reports
// underflow; neither changes the contents. Slot storage has no reset; only
// the count and result strobe are cleared.
module stable_min_priority_queue_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  opcode_i,
  input  logic signed [smpq_pkg::ValueW-1:0]    item_value_i,
  input  logic        [smpq_pkg::PrioW-1:0]     item_priority_i,
  output logic                                  result_valid_o,
  output logic        [smpq_pkg::StatusW-1:0]   status_o,
  output logic signed [smpq_pkg::ValueW-1:0]    head_value_o,
  output logic        [smpq_pkg::PrioW-1:0]     head_priority_o,
  output logic                                  is_empty_o,
  output logic                                  is_full_o,
  output logic        [smpq_pkg::EntryCntW-1:0] entry_count_o
);

  logic accept;
  logic empty, full;
  smpq_pkg::cell_ctrl_t ctrl;

  logic [smpq_pkg::CntW-1:0] count_q, count_d;
  logic                      result_valid_q;
  smpq_pkg::status_e         status_q, status_d;

  logic                               occ   [smpq_pkg::Capacity];
  logic                               ins   [smpq_pkg::Capacity];
  logic signed [smpq_pkg::ValueW-1:0] value [smpq_pkg::Capacity];
  logic        [smpq_pkg::PrioW-1:0]  prio  [smpq_pkg::Capacity];

  // Every request is taken in the cycle it is raised.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign empty = (count_q == '0);
  assign full  = (count_q == smpq_pkg::CntW'(smpq_pkg::Capacity));

  // Drop requests that would overflow or underflow before they reach the chain.
  always_comb begin
    ctrl.push = accept && (opcode_i == smpq_pkg::OpEnqueue) && !full;
    ctrl.pop  = accept && (opcode_i == smpq_pkg::OpDequeue) && !empty;
  end

  always_comb begin
    count_d  = count_q;
    status_d = smpq_pkg::StatusOk;
    if (ctrl.push) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop) begin
      count_d = count_q - 1'b1;
    end
    if (opcode_i == smpq_pkg::OpEnqueue) begin
      if (full) status_d = smpq_pkg::StatusOverflow;
    end else begin
      if (empty) status_d = smpq_pkg::StatusUnderflow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      result_valid_q <= 1'b0;
    end else begin
      count_q        <= count_d;
      result_valid_q <= accept;
    end
  end

  // Status is payload: only read while the strobe is high.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
    end
  end

  // Slot chain: each slot knows whether it holds a live entry from the count,
  // and hands its data and insert flag to its neighbors.
  for (genvar i = 0; i < smpq_pkg::Capacity; i++) begin : g_cell
    logic                               left_ins;
    logic signed [smpq_pkg::ValueW-1:0] left_value, right_value;
    logic        [smpq_pkg::PrioW-1:0]  left_prio, right_prio;

    assign occ[i] = (smpq_pkg::CntW'(i) < count_q);

    if (i == 0) begin : g_front
      assign left_ins   = 1'b0;
      assign left_value = item_value_i;
      assign left_prio  = item_priority_i;
    end else begin : g_inner
      assign left_ins   = ins[i-1];
      assign left_value = value[i-1];
      assign left_prio  = prio[i-1];
    end

    if (i == smpq_pkg::Capacity - 1) begin : g_back
      // the back slot becomes free on dequeue; hold its contents
      assign right_value = value[i];
      assign right_prio  = prio[i];
    end else begin : g_mid
      assign right_value = value[i+1];
      assign right_prio  = prio[i+1];
    end

    smpq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (occ[i]),
      .new_value_i   (item_value_i),
      .new_prio_i    (item_priority_i),
      .left_ins_i    (left_ins),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .ins_o         (ins[i]),
      .value_o       (value[i]),
      .prio_o        (prio[i])
    );
  end

  // Results come straight from state after the update edge.
  assign result_valid_o  = result_valid_q;
  assign status_o        = status_q;
  assign head_value_o    = empty ? '0 : value[0];
  assign head_priority_o = empty ? '0 : prio[0];
  assign is_empty_o      = empty;
  assign is_full_o       = full;
  assign entry_count_o   = smpq_pkg::EntryCntW'(count_q);

  // Count never runs past capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= smpq_pkg::CntW'(smpq_pkg::Capacity))
    else $error("occupancy above capacity");

  // Every accepted request yields a result on the next cycle.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("missing result strobe");

  // A successful dequeue removes exactly one entry.
  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |=> count_q == $past(count_q) - 1'b1)
    else $error("dequeue count mismatch");

  // Overflow is only reported on a full queue, underflow only on an empty one.
  a_overflow_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == smpq_pkg::StatusOverflow |-> is_full_o)
    else $error("overflow while not full");

  a_underflow_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == smpq_pkg::StatusUnderflow |-> is_empty_o)
    else $error("underflow while not empty");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for stable_min_priority_queue_core.
// Depends on rtl/smpq_pkg.sv, rtl/smpq_cell.sv and rtl/stable_min_priority_queue_core.sv; reads no files.
// Runs directed corner tests, then fill/drain rounds and random mixed traffic.
module tb_top;
  import smpq_pkg::*;

  // One result as the queue reports it after a request.
  typedef struct {
    status_e                    status;
    logic signed [ValueW-1:0]   head_value;
    logic        [PrioW-1:0]    head_priority;
    logic                       is_empty;
    logic                       is_full;
    logic        [EntryCntW-1:0] entry_count;
  } head_report_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         opcode_i = OpEnqueue;
  logic signed [ValueW-1:0]     item_value_i = '0;
  logic        [PrioW-1:0]      item_priority_i = '0;
  logic                         result_valid_o;
  logic        [StatusW-1:0]    status_o;
  logic signed [ValueW-1:0]     head_value_o;
  logic        [PrioW-1:0]      head_priority_o;
  logic                         is_empty_o;
  logic                         is_full_o;
  logic        [EntryCntW-1:0]  entry_count_o;

  // Shadow copy of the sorted store; slot 0 is the front.
  logic signed [ValueW-1:0]     shadow_value [Capacity];
  logic        [PrioW-1:0]      shadow_priority [Capacity];
  int                           shadow_count = 0;

  // Reports owed by the queue, oldest first.
  head_report_t                 head_reports_due [$];

  int                           idle_limit = 3;
  int                           fail_count = 0;
  int                           requests_taken = 0;
  int                           reports_checked = 0;
  int                           underflows_seen = 0;
  int                           overflows_seen = 0;
  int                           peak_depth = 0;

  stable_min_priority_queue_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .result_valid_o  (result_valid_o),
    .status_o        (status_o),
    .head_value_o    (head_value_o),
    .head_priority_o (head_priority_o),
    .is_empty_o      (is_empty_o),
    .is_full_o       (is_full_o),
    .entry_count_o   (entry_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one accepted request to the shadow store and return the report it owes.
  function automatic head_report_t advance_shadow_queue(opcode_e op,
                                                        logic signed [ValueW-1:0] val,
                                                        logic [PrioW-1:0] pri);
    head_report_t rep;
    int pos;
    rep.status = StatusOk;
    if (op == OpEnqueue) begin
      if (shadow_count >= Capacity) begin
        // Full: leave the store untouched and flag overflow.
        rep.status = StatusOverflow;
      end else begin
        // Find the first slot with a strictly larger priority; ties stay behind
        // older entries so equal priorities leave in arrival order.
        pos = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_priority[i] > pri) pos = i;
        end
        for (int i = shadow_count; i > pos; i--) begin
          shadow_value[i]    = shadow_value[i-1];
          shadow_priority[i] = shadow_priority[i-1];
        end
        shadow_value[pos]    = val;
        shadow_priority[pos] = pri;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      rep.status = StatusUnderflow;
    end else begin
      // Drop the front entry and advance the rest one slot.
      for (int i = 0; i + 1 < shadow_count; i++) begin
        shadow_value[i]    = shadow_value[i+1];
        shadow_priority[i] = shadow_priority[i+1];
      end
      shadow_count--;
    end
    rep.head_value    = (shadow_count > 0) ? shadow_value[0] : '0;
    rep.head_priority = (shadow_count > 0) ? shadow_priority[0] : '0;
    rep.is_empty      = (shadow_count == 0);
    rep.is_full       = (shadow_count >= Capacity);
    rep.entry_count   = EntryCntW'(shadow_count);
    if (shadow_count > peak_depth) peak_depth = shadow_count;
    return rep;
  endfunction

  // Track accepted requests and check every strobed result at the clock edge.
  // Handle acceptance first so a report strobed in the same cycle as its request would still find its entry.
  always @(posedge clk_i) begin
    head_report_t due;
    if (rst_ni) begin
      if (start === 1'b1 && busy === 1'b0) begin
        head_reports_due.push_back(advance_shadow_queue(opcode_e'(opcode_i),
                                                        item_value_i, item_priority_i));
        requests_taken++;
      end
      if (result_valid_o === 1'b1) begin
        if (head_reports_due.size() == 0) begin
          $error("result strobed with no request outstanding");
          fail_count++;
        end else begin
          due = head_reports_due.pop_front();
          reports_checked++;
          if (due.status == StatusUnderflow) underflows_seen++;
          if (due.status == StatusOverflow) overflows_seen++;
          if (status_o !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, status_o);
            fail_count++;
          end
          if (head_value_o !== due.head_value) begin
            $error("head_value: expected %0d, got %0d", due.head_value, head_value_o);
            fail_count++;
          end
          if (head_priority_o !== due.head_priority) begin
            $error("head_priority: expected %0d, got %0d", due.head_priority,
                   head_priority_o);
            fail_count++;
          end
          if (is_empty_o !== due.is_empty) begin
            $error("is_empty: expected %0b, got %0b", due.is_empty, is_empty_o);
            fail_count++;
          end
          if (is_full_o !== due.is_full) begin
            $error("is_full: expected %0b, got %0b", due.is_full, is_full_o);
            fail_count++;
          end
          if (entry_count_o !== due.entry_count) begin
            $error("entry_count: expected %0d, got %0d", due.entry_count, entry_count_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Send one request: idle a random number of cycles, then hold start until
  // an edge where busy is low takes it. Start stays high for a back-to-back request.
  task automatic send_request(input opcode_e op, input logic signed [ValueW-1:0] val,
                              input logic [PrioW-1:0] pri);
    int gap;
    gap = $urandom_range(0, idle_limit);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start           <= 1'b1;
    opcode_i        <= op;
    item_value_i    <= val;
    item_priority_i <= pri;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Dequeue on an empty queue right after reset: expect underflow, fields ignored.
  task automatic test_empty_dequeue();
    send_request(OpDequeue, 32'shFFFF_FFFF, 8'hFF);
  endtask

  // Extreme values and priorities, with a tie at priority zero behind the oldest.
  task automatic test_field_extremes();
    send_request(OpEnqueue, 32'sh7FFF_FFFF, 8'hFF);
    send_request(OpEnqueue, 32'sh8000_0000, 8'h00);
    send_request(OpEnqueue, 32'sh0000_0000, 8'hFF);
    send_request(OpEnqueue, -32'sd1, 8'h00);
  endtask

  // Drain everything, the last dequeue leaving the queue empty with zero head fields.
  task automatic test_last_entry_dequeue();
    repeat (4) send_request(OpDequeue, $urandom, PrioW'($urandom));
  endtask

  // Fill to capacity on three tied priority levels, then push into a full queue.
  task automatic test_full_overflow();
    for (int k = 0; k < Capacity; k++) begin
      send_request(OpEnqueue, ValueW'(k + 1), PrioW'((k % 3) * 100));
    end
    send_request(OpEnqueue, 32'sh5A5A_5A5A, 8'h00);
    send_request(OpEnqueue, 32'shA5A5_A5A5, 8'hFF);
  endtask

  // Full drain to underflow and full refill to overflow, random content, narrow
  // priority bands so ties are common. Starts from a full queue.
  task automatic test_fill_drain_rounds();
    int band;
    repeat (3) begin
      repeat (Capacity + 1) send_request(OpDequeue, $urandom, PrioW'($urandom));
      band = $urandom_range(0, 252);
      repeat (Capacity + 2) begin
        send_request(OpEnqueue, $urandom, PrioW'(band + $urandom_range(0, 3)));
      end
    end
  endtask

  // Mixed traffic in phases: each phase leans toward filling, draining or neither,
  // uses either full-range or banded priorities, and sometimes runs without idling.
  task automatic test_random_mix();
    int dequeue_pct;
    int band;
    int narrow;
    logic [PrioW-1:0] pri;
    repeat (30) begin
      case ($urandom_range(0, 2))
        0: dequeue_pct = 20;
        1: dequeue_pct = 50;
        default: dequeue_pct = 80;
      endcase
      idle_limit = ($urandom_range(0, 3) == 0) ? 0 : 3;
      narrow = $urandom_range(0, 1);
      band = $urandom_range(0, 252);
      repeat (50) begin
        if (narrow != 0) pri = PrioW'(band + $urandom_range(0, 3));
        else pri = PrioW'($urandom_range(0, 255));
        if ($urandom_range(1, 100) <= dequeue_pct) send_request(OpDequeue, $urandom, pri);
        else send_request(OpEnqueue, $urandom, pri);
      end
    end
    idle_limit = 3;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_dequeue();
    test_field_extremes();
    test_last_entry_dequeue();
    test_full_overflow();
    test_fill_drain_rounds();
    test_random_mix();

    // Stop issuing, let every outstanding report come back, then a short tail.
    start <= 1'b0;
    while (head_reports_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Covered %0d requests, %0d reports checked, peak depth %0d of %0d.",
             requests_taken, reports_checked, peak_depth, Capacity);
    $display("Saw %0d underflows and %0d overflows; %0d failures.",
             underflows_seen, overflows_seen, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (about 1700 requests, each
  // idling at most idle_limit cycles before it is taken).
  initial begin
    #200000;
    $display("timeout with %0d reports outstanding", head_reports_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/stable_min_priority_queue_core.sv
dv/tb_top.sv
